// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the dictionary block.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside reset.
`define WVDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define WVDS_NEVER(lbl, clk, rst_n, cond, msg) \
  `WVDS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define WVDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define WVDS_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/wvds_pkg.sv =====
// Shared types and codes of the word value dictionary block.
// No dependencies.
package wvds_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ValueW = 24;
  localparam int unsigned TotalW = 32;

  // Request opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // Result kinds
  localparam logic RK_TOTAL  = 1'b0;
  localparam logic RK_REJECT = 1'b1;

  // What a token in the cell chain stands for
  typedef enum logic [1:0] {
    TK_LOOKUP,
    TK_END,
    TK_REJECT
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e         kind;
    logic [KeyW-1:0]   key_upper;
    logic [KeyW-1:0]   key_lower;
    logic [ValueW-1:0] found;
  } tok_t;

endpackage

// ===== hw/rtl/word_value_dictionary_sum.sv =====
// Word value dictionary with running text total: top level.
// Depends on wvds_pkg, wvds_cell, wvds_tail and assert_macros.svh.
//
// Usage: requests arrive on the s_axis channel; tuser carries the opcode
// (insert, lookup, end of text), tdata the key and the value. Inserts store
// the word in the next free cell at once and give no result, unless the
// table is full, in which case a reject result is sent. Lookups add the
// value of the newest matching word (0 if none) to the text total; an
// end-of-text request sends the total with its saturation flag and clears it.
// Results leave on m_axis: tuser is the result kind, tdata total and flag.
//
// Structure: a chain of DICT_ENTRIES cells, oldest entry first. Each cell
// holds one entry and is one pipeline stage; a lookup passes one cell a
// cycle while not stalled, later matches overriding earlier ones, and carries
// the fill count taken at acceptance so entries added after it are not seen.
// Throughput: one request per cycle while results are taken. A result passes
// the DICT_ENTRIES cell registers and then the result register to m_axis.
// Reset empties the table, clears the total and drops work in flight.
// A stalled receiver holds the result register and freezes the whole chain,
// so s_axis_tready falls until the result is taken.
`include "assert_macros.svh"

module word_value_dictionary_sum import wvds_pkg::*; #(
  parameter int unsigned DICT_ENTRIES = 256,
  parameter int unsigned KEY_BYTES    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] key_upper, [127:64] key_lower, [151:128] word_value
  input  logic [151:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] text_total, [32] total_saturated, [39:33] zero
  output logic [39:0]  m_axis_tdata,
  // [0] result_kind
  output logic         m_axis_tuser
);

  localparam int unsigned CntW = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned IdxW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  // Key bits beyond KEY_BYTES are dropped on entry
  localparam logic [KeyW-1:0] UpperMask =
    (KEY_BYTES >= 8) ? '1 : ({KeyW{1'b1}} << (8 * (8 - KEY_BYTES)));
  localparam logic [KeyW-1:0] LowerMask =
    (KEY_BYTES <= 8) ? '0 : ({KeyW{1'b1}} << (8 * (16 - KEY_BYTES)));

  logic              adv;
  logic              accept;
  logic              full;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              wr_en;
  logic [KeyW-1:0]   key_upper;
  logic [KeyW-1:0]   key_lower;
  logic [ValueW-1:0] word_value;
  logic              head_vld;
  tok_t              head_tok;

  logic              vld_w [DICT_ENTRIES+1];
  tok_t              tok_w [DICT_ENTRIES+1];
  logic [CntW-1:0]   lim_w [DICT_ENTRIES+1];

  logic              res_kind;
  logic [TotalW-1:0] res_total;
  logic              res_sat;

  assign key_upper  = s_axis_tdata[63:0] & UpperMask;
  assign key_lower  = s_axis_tdata[127:64] & LowerMask;
  assign word_value = s_axis_tdata[151:128];

  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign full          = (cnt_q == CntW'(DICT_ENTRIES));
  assign wr_en         = accept && (s_axis_tuser == OP_INSERT) && !full;

  // Fill count: also the index of the next free cell
  always_comb begin
    cnt_d = cnt_q;
    if (wr_en) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Token entering the chain; stored inserts and unused opcodes leave a bubble
  always_comb begin
    head_vld           = 1'b0;
    head_tok.kind      = TK_LOOKUP;
    head_tok.key_upper = key_upper;
    head_tok.key_lower = key_lower;
    head_tok.found     = '0;
    if (accept) begin
      case (s_axis_tuser)
        OP_INSERT: begin
          head_vld      = full;
          head_tok.kind = TK_REJECT;
        end
        OP_LOOKUP: begin
          head_vld      = 1'b1;
          head_tok.kind = TK_LOOKUP;
        end
        OP_END: begin
          head_vld      = 1'b1;
          head_tok.kind = TK_END;
        end
        default: head_vld = 1'b0;
      endcase
    end
  end

  assign vld_w[0] = head_vld;
  assign tok_w[0] = head_tok;
  assign lim_w[0] = cnt_q;

  for (genvar i = 0; i < DICT_ENTRIES; i++) begin : g_cell
    wvds_cell #(
      .IDX   (i),
      .IDX_W (IdxW),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .adv_i          (adv),
      .wr_en_i        (wr_en),
      .wr_idx_i       (cnt_q[IdxW-1:0]),
      .wr_key_upper_i (key_upper),
      .wr_key_lower_i (key_lower),
      .wr_value_i     (word_value),
      .vld_i          (vld_w[i]),
      .tok_i          (tok_w[i]),
      .lim_i          (lim_w[i]),
      .vld_o          (vld_w[i+1]),
      .tok_o          (tok_w[i+1]),
      .lim_o          (lim_w[i+1])
    );
  end

  wvds_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (vld_w[DICT_ENTRIES]),
    .tok_i       (tok_w[DICT_ENTRIES]),
    .adv_o       (adv),
    .res_vld_o   (m_axis_tvalid),
    .res_kind_o  (res_kind),
    .res_total_o (res_total),
    .res_sat_o   (res_sat),
    .res_rdy_i   (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, res_sat, res_total};
  assign m_axis_tuser = res_kind;

  // Checks
  `WVDS_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CntW'(DICT_ENTRIES),
    "fill count beyond table size")
  `WVDS_ASSERT(a_stall_blocks, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready,
    "chain advanced while result stalled")
  `WVDS_ASSERT(a_insert_fill, clk_i, rst_ni,
    wr_en |=> (cnt_q == $past(cnt_q) + CntW'(1)),
    "stored insert did not bump fill count")
  `WVDS_ASSERT(a_reject_zero, clk_i, rst_ni,
    (m_axis_tvalid && (m_axis_tuser == RK_REJECT)) |-> (m_axis_tdata == 40'd0),
    "reject result carries a total")

endmodule

// ===== hw/rtl/wvds_cell.sv =====
// One dictionary cell: holds one entry and forms one stage of the lookup chain.
// Depends on wvds_pkg.
module wvds_cell import wvds_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 8,
  parameter int unsigned CNT_W = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  // entry write
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  logic [KeyW-1:0]   wr_key_upper_i,
  input  logic [KeyW-1:0]   wr_key_lower_i,
  input  logic [ValueW-1:0] wr_value_i,
  // chain in
  input  logic              vld_i,
  input  tok_t              tok_i,
  input  logic [CNT_W-1:0]  lim_i,
  // chain out
  output logic              vld_o,
  output tok_t              tok_o,
  output logic [CNT_W-1:0]  lim_o
);

  logic [KeyW-1:0]   key_upper_q;
  logic [KeyW-1:0]   key_lower_q;
  logic [ValueW-1:0] value_q;
  logic              vld_q;
  tok_t              tok_q, tok_d;
  logic [CNT_W-1:0]  lim_q;
  logic              hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IDX_W'(IDX))) begin
      key_upper_q <= wr_key_upper_i;
      key_lower_q <= wr_key_lower_i;
      value_q     <= wr_value_i;
    end
  end

  // Only entries stored before the lookup was taken count; later ones are newer.
  assign hit = (tok_i.kind == TK_LOOKUP) && (CNT_W'(IDX) < lim_i) &&
               (tok_i.key_upper == key_upper_q) && (tok_i.key_lower == key_lower_q);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      lim_q <= lim_i;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign lim_o = lim_q;

endmodule

// ===== hw/rtl/wvds_tail.sv =====
// End of the cell chain: running text total and the result register.
// Depends on wvds_pkg.
module wvds_tail import wvds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  tok_t              tok_i,
  output logic              adv_o,
  output logic              res_vld_o,
  output logic              res_kind_o,
  output logic [TotalW-1:0] res_total_o,
  output logic              res_sat_o,
  input  logic              res_rdy_i
);

  logic [TotalW-1:0] total_q, total_d;
  logic              sat_q, sat_d;
  logic              res_vld_q, res_vld_d;
  logic              res_kind_q, res_kind_d;
  logic [TotalW-1:0] res_total_q, res_total_d;
  logic              res_sat_q, res_sat_d;
  logic [TotalW:0]   sum;

  assign adv_o = !res_vld_q || res_rdy_i;
  assign sum   = {1'b0, total_q} + (TotalW+1)'(tok_i.found);

  always_comb begin
    total_d     = total_q;
    sat_d       = sat_q;
    res_vld_d   = res_vld_q && !res_rdy_i;
    res_kind_d  = res_kind_q;
    res_total_d = res_total_q;
    res_sat_d   = res_sat_q;
    if (adv_o && vld_i) begin
      case (tok_i.kind)
        TK_LOOKUP: begin
          if (sum[TotalW]) begin
            total_d = '1;
            sat_d   = 1'b1;
          end else begin
            total_d = sum[TotalW-1:0];
          end
        end
        TK_END: begin
          res_vld_d   = 1'b1;
          res_kind_d  = RK_TOTAL;
          res_total_d = total_q;
          res_sat_d   = sat_q;
          total_d     = '0;
          sat_d       = 1'b0;
        end
        TK_REJECT: begin
          res_vld_d   = 1'b1;
          res_kind_d  = RK_REJECT;
          res_total_d = '0;
          res_sat_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      sat_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      total_q   <= total_d;
      sat_q     <= sat_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q  <= res_kind_d;
    res_total_q <= res_total_d;
    res_sat_q   <= res_sat_d;
  end

  assign res_vld_o   = res_vld_q;
  assign res_kind_o  = res_kind_q;
  assign res_total_o = res_total_q;
  assign res_sat_o   = res_sat_q;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for word_value_dictionary_sum: directed and random
// request streams, checked against an in-bench model of the dictionary and total.
// Depends on wvds_pkg and the word_value_dictionary_sum RTL.
module tb import wvds_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DICT_ENTRIES = 256;
  // All 16 key bytes are significant, so keys are compared whole.
  localparam int unsigned KEY_BYTES    = 16;
  localparam int unsigned LATENCY      = DICT_ENTRIES + 1;
  localparam int unsigned IDLE_PCT     = 17;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [TotalW-1:0] total;
    logic              clipped;
  } outcome_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tuser;

  // Model of the dictionary: entries in arrival order, plus the open text total
  logic [KeyW-1:0]   dict_upper [DICT_ENTRIES];
  logic [KeyW-1:0]   dict_lower [DICT_ENTRIES];
  logic [ValueW-1:0] dict_value [DICT_ENTRIES];
  int unsigned       dict_fill;
  logic [TotalW-1:0] text_sum;
  logic              text_clipped;

  outcome_t    pending_outcomes[$];
  int unsigned failures;
  int unsigned requests_sent;
  int unsigned totals_checked;
  int unsigned clipped_totals;
  int unsigned refusals_checked;
  bit          steady_flow;

  word_value_dictionary_sum #(
    .DICT_ENTRIES(DICT_ENTRIES),
    .KEY_BYTES   (KEY_BYTES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Result side back-pressure; none while steady_flow is set
  always @(posedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d results still outstanding", pending_outcomes.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endfunction

  // Applies one request to the model; returns 1 with the outcome when it makes a result.
  function automatic bit model_request(input logic [1:0] op, input logic [KeyW-1:0] ku,
                                       input logic [KeyW-1:0] kl,
                                       input logic [ValueW-1:0] val, output outcome_t res);
    logic [ValueW-1:0] found;
    logic [TotalW:0]   sum;
    int unsigned       i;
    found = '0;
    res   = '0;
    case (op)
      OP_INSERT: begin
        if (dict_fill >= DICT_ENTRIES) begin
          res.kind = RK_REJECT;
          return 1'b1;
        end
        dict_upper[dict_fill] = ku;
        dict_lower[dict_fill] = kl;
        dict_value[dict_fill] = val;
        dict_fill++;
      end
      OP_LOOKUP: begin
        // newest match wins, so search from the top down
        i = dict_fill;
        while (i > 0) begin
          i--;
          if (dict_upper[i] == ku && dict_lower[i] == kl) begin
            found = dict_value[i];
            break;
          end
        end
        sum = {1'b0, text_sum} + {{(TotalW + 1 - ValueW){1'b0}}, found};
        if (sum[TotalW]) begin
          text_sum     = '1;
          text_clipped = 1'b1;
        end else begin
          text_sum = sum[TotalW-1:0];
        end
      end
      OP_END: begin
        res.kind     = RK_TOTAL;
        res.total    = text_sum;
        res.clipped  = text_clipped;
        text_sum     = '0;
        text_clipped = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Result checker: every accepted result against the oldest outstanding outcome
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        note_failure($sformatf("unexpected result kind %0d tdata %h",
                               m_axis_tuser, m_axis_tdata));
      end else begin
        want = pending_outcomes.pop_front();
        if (want.kind == RK_REJECT) begin
          refusals_checked++;
        end else begin
          totals_checked++;
          if (want.clipped) clipped_totals++;
        end
        if (m_axis_tuser !== want.kind) begin
          note_failure($sformatf("result_kind exp %0d got %0d", want.kind, m_axis_tuser));
        end
        if (m_axis_tdata[31:0] !== want.total) begin
          note_failure($sformatf("text_total exp %h got %h", want.total, m_axis_tdata[31:0]));
        end
        if (m_axis_tdata[32] !== want.clipped) begin
          note_failure($sformatf("total_saturated exp %0d got %0d",
                                 want.clipped, m_axis_tdata[32]));
        end
      end
    end
  end

  // Sends one request; tvalid is left high so back-to-back requests need no re-raise.
  task automatic send_request(input logic [1:0] op, input logic [KeyW-1:0] ku,
                              input logic [KeyW-1:0] kl, input logic [ValueW-1:0] val);
    outcome_t res;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, kl, ku};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_UNUSED) requests_sent++;
    if (model_request(op, ku, kl, val, res)) pending_outcomes.push_back(res);
  endtask

  // Sender holds off until every outstanding result has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Word text to key halves: byte 0 in the top of key_upper, zero padded
  function automatic void pack_word(input string text, output logic [KeyW-1:0] ku,
                                    output logic [KeyW-1:0] kl);
    int i;
    ku = '0;
    kl = '0;
    for (i = 0; i < text.len() && i < 16; i++) begin
      if (i < 8) ku[63 - 8*i -: 8] = text[i];
      else       kl[63 - 8*(i-8) -: 8] = text[i];
    end
  endfunction

  // Mostly lowercase words of 1..16 bytes, sometimes raw bit patterns
  function automatic void random_word(output logic [KeyW-1:0] ku, output logic [KeyW-1:0] kl);
    int unsigned len;
    int unsigned i;
    if ($urandom_range(9) < 3) begin
      ku = {$urandom, $urandom};
      kl = {$urandom, $urandom};
    end else begin
      ku  = '0;
      kl  = '0;
      len = $urandom_range(16, 1);
      for (i = 0; i < len; i++) begin
        if (i < 8) ku[63 - 8*i -: 8] = 8'h61 + 8'($urandom_range(25));
        else       kl[63 - 8*(i-8) -: 8] = 8'h61 + 8'($urandom_range(25));
      end
    end
  endfunction

  // One random request inside a text: lookups dominate, mostly of stored words
  task automatic random_token(input bit allow_insert);
    logic [KeyW-1:0] ku;
    logic [KeyW-1:0] kl;
    int unsigned     pick;
    int unsigned     roll;
    int unsigned     flip;
    roll = $urandom_range(99);
    random_word(ku, kl);
    if (dict_fill > 0) begin
      pick = $urandom_range(dict_fill - 1);
    end else begin
      pick = 0;
    end
    if (roll < 22 && allow_insert) begin
      // repeated word with a fresh value, or a new word
      if (dict_fill > 0 && $urandom_range(9) < 4) begin
        ku = dict_upper[pick];
        kl = dict_lower[pick];
      end
      send_request(OP_INSERT, ku, kl, 24'($urandom));
    end else if (roll < 27) begin
      send_request(OP_UNUSED, ku, kl, 24'($urandom));
    end else begin
      roll = $urandom_range(99);
      if (dict_fill > 0 && roll < 80) begin
        ku = dict_upper[pick];
        kl = dict_lower[pick];
        // near miss: one bit away from a stored word
        if (roll >= 65) begin
          flip = $urandom_range(127);
          if (flip < 64) ku[flip] = ~ku[flip];
          else           kl[flip - 64] = ~kl[flip - 64];
        end
      end
      send_request(OP_LOOKUP, ku, kl, 24'($urandom));
    end
  endtask

  task automatic send_word(input logic [1:0] op, input string text,
                           input logic [ValueW-1:0] val);
    logic [KeyW-1:0] ku;
    logic [KeyW-1:0] kl;
    pack_word(text, ku, kl);
    send_request(op, ku, kl, val);
  endtask

  // Plain inserts and lookups, misses, value extremes, empty text
  task automatic test_lookup_total();
    send_word(OP_INSERT, "the", 24'd5);
    send_word(OP_INSERT, "cat", 24'hFF_FFFF);
    send_request(OP_INSERT, '1, '1, 24'd0);
    send_word(OP_LOOKUP, "the", 24'hFF_FFFF);
    send_word(OP_LOOKUP, "cat", 24'd0);
    send_request(OP_LOOKUP, '1, '1, 24'h5A_5A5A);
    send_word(OP_LOOKUP, "dog", 24'd0);
    send_word(OP_END, "", 24'hFF_FFFF);
    send_word(OP_END, "zzzzzzzzzzzzzzzz", 24'd0);
  endtask

  // Empty word, the period word, a full-length word and a repeated word
  task automatic test_special_words();
    send_word(OP_LOOKUP, "", 24'd0);
    send_word(OP_LOOKUP, ".", 24'd0);
    send_word(OP_INSERT, "", 24'd7);
    send_word(OP_INSERT, ".", 24'd3);
    send_word(OP_INSERT, "abcdefghijklmnop", 24'd11);
    send_word(OP_INSERT, "the", 24'd9);
    send_word(OP_LOOKUP, "", 24'd0);
    send_word(OP_LOOKUP, ".", 24'd0);
    send_word(OP_LOOKUP, "abcdefghijklmnop", 24'd0);
    send_word(OP_LOOKUP, "abcdefghijklmno", 24'd0);
    send_word(OP_LOOKUP, "the", 24'd0);
    send_word(OP_END, "", 24'd0);
  endtask

  // Opcode 3 must leave the dictionary and the total untouched
  task automatic test_unused_opcode();
    send_request(OP_UNUSED, '1, '1, '1);
    send_word(OP_LOOKUP, "cat", 24'd0);
    send_word(OP_UNUSED, "cat", 24'd1);
    send_word(OP_END, "", 24'd0);
  endtask

  // Total reaches exactly the maximum, a miss keeps it, then it clips and sticks
  task automatic test_saturation();
    int unsigned n;
    steady_flow = 1'b1;
    send_word(OP_INSERT, "max", 24'hFF_FFFF);
    send_word(OP_INSERT, "tail", 24'd255);
    send_word(OP_INSERT, "one", 24'd1);
    for (n = 0; n < 256; n++) send_word(OP_LOOKUP, "max", 24'($urandom));
    send_word(OP_LOOKUP, "tail", 24'd0);
    send_word(OP_LOOKUP, "nothing", 24'd0);
    send_word(OP_LOOKUP, "one", 24'd0);
    send_word(OP_LOOKUP, "max", 24'd0);
    send_word(OP_END, "", 24'd0);
    // total and flag must both be clear for the next text
    send_word(OP_LOOKUP, "one", 24'd0);
    send_word(OP_END, "", 24'd0);
    steady_flow = 1'b0;
  endtask

  // Random texts of 0..12 words; stops on item count and enough totals seen
  task automatic test_random_texts();
    int unsigned first_item;
    int unsigned texts;
    int unsigned len;
    int unsigned n;
    first_item = requests_sent;
    texts      = 0;
    while (requests_sent < first_item + 280 || texts < 40) begin
      len = $urandom_range(12);
      for (n = 0; n < len; n++) random_token(dict_fill < 200);
      send_word(OP_END, "", 24'($urandom));
      texts++;
      if (texts % 15 == 0) wait_drained();
    end
  endtask

  // Fill the table, then inserts are refused while lookups carry on
  task automatic test_table_full();
    logic [KeyW-1:0]   ku;
    logic [KeyW-1:0]   kl;
    int unsigned       n;
    while (dict_fill < DICT_ENTRIES) begin
      random_word(ku, kl);
      send_request(OP_INSERT, ku, kl, 24'($urandom));
    end
    send_request(OP_LOOKUP, ku, kl, 24'd0);
    send_request(OP_LOOKUP, dict_upper[0], dict_lower[0], 24'd0);
    send_word(OP_INSERT, "overflow", 24'h12_3456);
    send_word(OP_LOOKUP, "overflow", 24'd0);
    send_word(OP_INSERT, "the", 24'h00_0001);
    send_word(OP_LOOKUP, "the", 24'd0);
    send_word(OP_END, "", 24'd0);
    for (n = 0; n < 3; n++) begin
      repeat ($urandom_range(8)) random_token(1'b1);
      send_word(OP_END, "", 24'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    m_axis_tready = 1'b0;
    steady_flow   = 1'b0;
    dict_fill     = 0;
    text_sum      = '0;
    text_clipped  = 1'b0;
    failures      = 0;
    requests_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lookup_total();
    test_special_words();
    test_unused_opcode();
    wait_drained();
    test_saturation();
    wait_drained();
    test_random_texts();
    wait_drained();
    test_table_full();

    wait_drained();
    repeat (LATENCY + 16) @(posedge clk_i);
    if (pending_outcomes.size() != 0) note_failure("results left outstanding at the end");

    $display("Run covered %0d requests with %0d entries stored; %0d text totals checked,",
             requests_sent, dict_fill, totals_checked);
    $display("%0d of them clipped, and %0d inserts refused on a full table; %0d failures.",
             clipped_totals, refusals_checked, failures);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wvds_pkg.sv
hw/rtl/wvds_cell.sv
hw/rtl/wvds_tail.sv
hw/rtl/word_value_dictionary_sum.sv
tb/sv/tb.sv
